### src/tmss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmss_pkg: shared types and constants for the trimmed-mean statistics block
// Channel count, widths, operation and status codes, and the records that
// pass between the front end, the queue, the back end and the divider.
// ----------------------------------------------------------------------------
package tmss_pkg;

  // Block configuration
  localparam int NUM_CHANNELS = 16;   // 1 .. 32
  localparam int SAMPLE_BITS  = 12;   // 8 .. 16
  localparam int COUNT_BITS   = 16;   // 4 .. 24
  localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Port field widths
  localparam int MODE_W      = 2;
  localparam int CHANNEL_W   = 5;
  localparam int IN_SAMPLE_W = 12;
  localparam int AVG_W       = 12;
  localparam int COUNT_W     = 16;
  localparam int EXTREME_W   = 12;
  localparam int STATUS_W    = 2;

  // Queue between front and back end (power of two, at least 2)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Divider step counter
  localparam int DIV_STEP_W  = $clog2(SUM_BITS);

  // Samples dropped from the mean: the largest and the smallest
  localparam int TRIM_EDGES  = 2;

  typedef logic [CH_W-1:0]        ch_t;
  typedef logic [SAMPLE_BITS-1:0] smp_t;
  typedef logic [COUNT_BITS-1:0]  cnt_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [DIV_STEP_W-1:0]  div_step_t;
  typedef logic [QPTR_W-1:0]      qptr_t;
  typedef logic [QPTR_W:0]        qfill_t;

  // Count value at which further adds are refused
  localparam cnt_t COUNT_FULL = {COUNT_BITS{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BADCH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_READ,
    OP_CLEAR,
    OP_BADCH
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_UPDATE,
    BK_PREP,
    BK_DIV,
    BK_DONE
  } bk_state_t;

  // Classified item as queued between front and back end
  typedef struct packed {
    op_t  op;
    ch_t  ch;
    smp_t sample;
  } item_t;

  // Divider request and response
  typedef struct packed {
    logic start;
    sum_t num;
    cnt_t den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    sum_t quot;
  } div_rsp_t;

endpackage

### src/tmss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmss_if: item and result channels
// Valid/ready channels carrying one command beat in and one result beat out.
// ----------------------------------------------------------------------------
interface tmss_in_if;
  logic                            valid;
  logic                            ready;
  logic [tmss_pkg::MODE_W-1:0]     mode;
  logic [tmss_pkg::CHANNEL_W-1:0]  channel;
  logic [tmss_pkg::IN_SAMPLE_W-1:0] sample;

  modport source (output valid, mode, channel, sample, input ready);
  modport sink   (input valid, mode, channel, sample, output ready);
endinterface

interface tmss_out_if;
  logic                           valid;
  logic                           ready;
  logic [tmss_pkg::AVG_W-1:0]     average;
  logic [tmss_pkg::COUNT_W-1:0]   count;
  logic [tmss_pkg::EXTREME_W-1:0] maximum;
  logic [tmss_pkg::EXTREME_W-1:0] minimum;
  logic [tmss_pkg::STATUS_W-1:0]  status;

  modport source (output valid, average, count, maximum, minimum, status, input ready);
  modport sink   (input valid, average, count, maximum, minimum, status, output ready);
endinterface

### src/trimmed_mean_sample_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_mean_sample_statistics: per-channel sample statistics
// Add, read and clear commands on per-channel count, sum, maximum and
// minimum, each answered by one result beat with the trimmed mean.
// ----------------------------------------------------------------------------
// Every command beat gets exactly one result beat describing the addressed
// channel after the command. The intake side accepts beats into a two-entry
// queue, so it keeps taking commands while the back end works and while a
// result waits for the sink. The back end handles one command at a time,
// stepping through pop, update, setup and result, and when the mean needs a
// division it waits in between for the bit-serial divider, which produces
// one quotient bit per sum bit. The divider is the rate-setting unit. No
// clearing pass is needed after reset; all channels read as cleared at once.
// ----------------------------------------------------------------------------
module trimmed_mean_sample_statistics (
  input logic         clk,
  input logic         rst_n,
  tmss_in_if.sink     in_if,
  tmss_out_if.source  out_if
);

  logic               q_push, q_ready, q_valid, q_pop;
  tmss_pkg::item_t    q_in_item, q_head;
  tmss_pkg::div_req_t div_req;
  tmss_pkg::div_rsp_t div_rsp;

  tmss_front u_front (
    .in_if   (in_if),
    .q_ready (q_ready),
    .push    (q_push),
    .item    (q_in_item)
  );

  tmss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .ready     (q_ready),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  tmss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  tmss_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_head),
    .pop     (q_pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_if  (out_if)
  );

  // Never pop an empty queue, never start the divider while it runs
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command popped from empty queue");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // Bad-channel beats carry all-zero statistics
  a_badch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.status == tmss_pkg::ST_BADCH |->
      out_if.count == '0 && out_if.maximum == '0 && out_if.minimum == '0 &&
      out_if.average == '0)
    else $error("bad-channel result with nonzero fields");

  // A nonempty channel's mean lies between its extremes
  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.count != '0 |->
      out_if.minimum <= out_if.average && out_if.average <= out_if.maximum)
    else $error("trimmed mean outside sample range");

  // A refused add reports a full count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.status == tmss_pkg::ST_FULL |->
      out_if.count == tmss_pkg::COUNT_W'(tmss_pkg::COUNT_FULL))
    else $error("full status without full count");

endmodule

### src/tmss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmss_front: command intake and classification
// Accepts command beats while the queue has room, checks the channel range
// and reduces mode and channel to one operation code for the back end.
// ----------------------------------------------------------------------------
module tmss_front (
  tmss_in_if.sink          in_if,
  input  logic             q_ready,
  output logic             push,
  output tmss_pkg::item_t  item
);

  localparam logic [tmss_pkg::CHANNEL_W:0] CH_LIMIT =
    (tmss_pkg::CHANNEL_W + 1)'(tmss_pkg::NUM_CHANNELS);

  logic bad_ch;

  // Take a beat whenever the queue can hold it
  assign in_if.ready = q_ready;
  assign push        = in_if.valid & q_ready;

  // Flag channels beyond the implemented set
  assign bad_ch = {1'b0, in_if.channel} >= CH_LIMIT;

  // Classify the beat
  always_comb begin
    item.ch     = tmss_pkg::ch_t'(in_if.channel);
    item.sample = tmss_pkg::smp_t'(in_if.sample);
    if (bad_ch) begin
      item.op = tmss_pkg::OP_BADCH;
    end else begin
      case (tmss_pkg::mode_t'(in_if.mode))
        tmss_pkg::MODE_ADD:   item.op = tmss_pkg::OP_ADD;
        tmss_pkg::MODE_CLEAR: item.op = tmss_pkg::OP_CLEAR;
        default:              item.op = tmss_pkg::OP_READ;
      endcase
    end
  end

endmodule

### src/tmss_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmss_queue: short command queue
// Small FIFO of classified commands that decouples intake from processing.
// ----------------------------------------------------------------------------
module tmss_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tmss_pkg::item_t push_item,
  output logic            ready,
  output logic            valid,
  output tmss_pkg::item_t head,
  input  logic            pop
);

  tmss_pkg::item_t  entry_r [tmss_pkg::QUEUE_DEPTH];
  tmss_pkg::qptr_t  wr_ptr_r, wr_ptr_nxt;
  tmss_pkg::qptr_t  rd_ptr_r, rd_ptr_nxt;
  tmss_pkg::qfill_t fill_r, fill_nxt;

  assign ready = fill_r != tmss_pkg::qfill_t'(tmss_pkg::QUEUE_DEPTH);
  assign valid = fill_r != '0;
  assign head  = entry_r[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store incoming beats
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### src/tmss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmss_div: sequential unsigned divider
// Restoring division of the sum by the sample count, one quotient bit per
// cycle until all SUM_BITS quotient bits are in.
// ----------------------------------------------------------------------------
module tmss_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tmss_pkg::div_req_t req,
  output tmss_pkg::div_rsp_t rsp
);

  localparam int CB = tmss_pkg::COUNT_BITS;
  localparam int SB = tmss_pkg::SUM_BITS;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  tmss_pkg::div_step_t step_r, step_nxt;
  tmss_pkg::sum_t      quo_r, quo_nxt;
  logic [CB:0]         rem_r, rem_nxt;
  tmss_pkg::cnt_t      den_r;

  logic [CB:0] trial;
  logic        fits;
  logic        last_step;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial     = {rem_r[CB-1:0], quo_r[SB-1]};
  assign fits      = trial >= {1'b0, den_r};
  assign last_step = step_r == tmss_pkg::div_step_t'(SB - 1);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = req.num;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? trial - {1'b0, den_r} : trial;
      quo_nxt  = {quo_r[SB-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    if (req.start) begin
      den_r <= req.den;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

### src/tmss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmss_back: statistics store and result sequencer
// Pops one command, updates the channel's count, sum and extremes, sets up
// the trimmed-mean division and holds the result beat for the sink.
// ----------------------------------------------------------------------------
module tmss_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tmss_pkg::item_t    q_item,
  output logic               pop,
  output tmss_pkg::div_req_t div_req,
  input  tmss_pkg::div_rsp_t div_rsp,
  tmss_out_if.source         out_if
);

  localparam int NCH = tmss_pkg::NUM_CHANNELS;

  tmss_pkg::bk_state_t state_r, state_nxt;

  // Per-channel store; a set first flag means the channel reads as cleared
  tmss_pkg::cnt_t   cnt_mem_r [NCH];
  tmss_pkg::sum_t   sum_mem_r [NCH];
  tmss_pkg::smp_t   max_mem_r [NCH];
  tmss_pkg::smp_t   min_mem_r [NCH];
  logic [NCH-1:0]   first_r;

  tmss_pkg::item_t  item_r;
  tmss_pkg::cnt_t   st_cnt_r;
  tmss_pkg::sum_t   st_sum_r;
  tmss_pkg::smp_t   st_max_r;
  tmss_pkg::smp_t   st_min_r;
  tmss_pkg::status_t stat_r;
  logic             zero_avg_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [tmss_pkg::AVG_W-1:0]     out_avg_r;
  logic [tmss_pkg::COUNT_W-1:0]   out_cnt_r;
  logic [tmss_pkg::EXTREME_W-1:0] out_max_r;
  logic [tmss_pkg::EXTREME_W-1:0] out_min_r;
  tmss_pkg::status_t              out_stat_r;

  // Control strobes
  logic upd_en, prep_en, res_load;

  // Update-stage values
  logic              cur_first;
  tmss_pkg::cnt_t    cur_cnt, new_cnt;
  tmss_pkg::sum_t    cur_sum, new_sum;
  tmss_pkg::smp_t    cur_max, new_max;
  tmss_pkg::smp_t    cur_min, new_min;
  tmss_pkg::status_t new_stat;
  logic              wr_stats, clr_stats;

  // Prep-stage values
  logic           small_n, zero_c;
  tmss_pkg::sum_t edges;

  // Read the addressed channel
  always_comb begin
    cur_first = first_r[item_r.ch];
    cur_cnt   = cur_first ? '0 : cnt_mem_r[item_r.ch];
    cur_sum   = cur_first ? '0 : sum_mem_r[item_r.ch];
    cur_max   = cur_first ? '0 : max_mem_r[item_r.ch];
    cur_min   = cur_first ? '1 : min_mem_r[item_r.ch];
  end

  // Apply the command to the channel statistics
  always_comb begin
    new_cnt   = cur_cnt;
    new_sum   = cur_sum;
    new_max   = cur_max;
    new_min   = cur_min;
    new_stat  = tmss_pkg::ST_OK;
    wr_stats  = 1'b0;
    clr_stats = 1'b0;
    case (item_r.op)
      tmss_pkg::OP_ADD: begin
        if (!cur_first && cur_cnt == tmss_pkg::COUNT_FULL) begin
          new_stat = tmss_pkg::ST_FULL;
        end else if (cur_first) begin
          new_cnt  = tmss_pkg::cnt_t'(1);
          new_sum  = tmss_pkg::sum_t'(item_r.sample);
          new_max  = item_r.sample;
          new_min  = item_r.sample;
          wr_stats = 1'b1;
        end else begin
          new_cnt  = cur_cnt + 1'b1;
          new_sum  = cur_sum + tmss_pkg::sum_t'(item_r.sample);
          new_max  = (item_r.sample > cur_max) ? item_r.sample : cur_max;
          new_min  = (item_r.sample < cur_min) ? item_r.sample : cur_min;
          wr_stats = 1'b1;
        end
      end
      tmss_pkg::OP_CLEAR: begin
        new_cnt   = '0;
        new_sum   = '0;
        new_max   = '0;
        new_min   = '1;
        clr_stats = 1'b1;
      end
      tmss_pkg::OP_BADCH: begin
        new_cnt  = '0;
        new_sum  = '0;
        new_max  = '0;
        new_min  = '0;
        new_stat = tmss_pkg::ST_BADCH;
      end
      default: begin
      end
    endcase
  end

  // Set up the trimmed mean: plain mean for one or two samples
  always_comb begin
    edges   = tmss_pkg::sum_t'(st_max_r) + tmss_pkg::sum_t'(st_min_r);
    small_n = st_cnt_r <= tmss_pkg::cnt_t'(tmss_pkg::TRIM_EDGES);
    zero_c  = (st_cnt_r == '0) || (!small_n && st_sum_r < edges);
    div_req.start = prep_en && !zero_c;
    div_req.num   = small_n ? st_sum_r : st_sum_r - edges;
    div_req.den   = small_n ? st_cnt_r : st_cnt_r - tmss_pkg::cnt_t'(tmss_pkg::TRIM_EDGES);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tmss_pkg::BK_IDLE:   if (q_valid) state_nxt = tmss_pkg::BK_UPDATE;
      tmss_pkg::BK_UPDATE: state_nxt = tmss_pkg::BK_PREP;
      tmss_pkg::BK_PREP:   state_nxt = zero_c ? tmss_pkg::BK_DONE : tmss_pkg::BK_DIV;
      tmss_pkg::BK_DIV:    if (div_rsp.done) state_nxt = tmss_pkg::BK_DONE;
      tmss_pkg::BK_DONE:   if (res_load) state_nxt = tmss_pkg::BK_IDLE;
      default:             state_nxt = tmss_pkg::BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop      = 1'b0;
    upd_en   = 1'b0;
    prep_en  = 1'b0;
    res_load = 1'b0;
    case (state_r)
      tmss_pkg::BK_IDLE:   pop      = q_valid;
      tmss_pkg::BK_UPDATE: upd_en   = 1'b1;
      tmss_pkg::BK_PREP:   prep_en  = 1'b1;
      tmss_pkg::BK_DONE:   res_load = !out_valid_r || out_if.ready;
      default: begin
      end
    endcase
  end

  // Hold the result beat until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmss_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      first_r     <= '1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (upd_en && wr_stats) begin
        first_r[item_r.ch] <= 1'b0;
      end else if (upd_en && clr_stats) begin
        first_r[item_r.ch] <= 1'b1;
      end
    end
  end

  // Datapath registers and channel store
  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= q_item;
    end
    if (upd_en) begin
      st_cnt_r <= new_cnt;
      st_sum_r <= new_sum;
      st_max_r <= new_max;
      st_min_r <= new_min;
      stat_r   <= new_stat;
    end
    if (upd_en && wr_stats) begin
      cnt_mem_r[item_r.ch] <= new_cnt;
      sum_mem_r[item_r.ch] <= new_sum;
      max_mem_r[item_r.ch] <= new_max;
      min_mem_r[item_r.ch] <= new_min;
    end
    if (prep_en) begin
      zero_avg_r <= zero_c;
    end
    if (res_load) begin
      out_avg_r  <= zero_avg_r ? '0 : tmss_pkg::AVG_W'(div_rsp.quot);
      out_cnt_r  <= tmss_pkg::COUNT_W'(st_cnt_r);
      out_max_r  <= tmss_pkg::EXTREME_W'(st_max_r);
      out_min_r  <= tmss_pkg::EXTREME_W'(st_min_r);
      out_stat_r <= stat_r;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.average = out_avg_r;
  assign out_if.count   = out_cnt_r;
  assign out_if.maximum = out_max_r;
  assign out_if.minimum = out_min_r;
  assign out_if.status  = out_stat_r;

endmodule
